// File: sv/ebs_pkg.sv
`default_nettype none

package ebs_pkg;

  // result slots one input beat can fill
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);
  localparam int unsigned NUM_W       = $clog2(MAX_RESULTS + 1);

  localparam int unsigned COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] STUFF_OFFSET = 8'h20;

  // register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  localparam logic [7:0] START_RESET  = 8'h01;
  localparam logic [7:0] STOP_RESET   = 8'h04;
  localparam logic [7:0] ESCAPE_RESET = 8'h10;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       first_in;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               out_valid;
    logic               last_out;
    logic [COUNT_W-1:0] byte_count;
  } out_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] escape_code;
  } cfg_t;

  // all results of one input beat, in order
  typedef struct packed {
    out_t [MAX_RESULTS-1:0] slot;
    logic [NUM_W-1:0]       num;
  } burst_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

  function automatic out_t make_res(input logic [7:0] b, input logic v, input logic l,
                                    input logic [COUNT_W-1:0] c);
    out_t r;
    r.out_byte   = v ? b : 8'h00;
    r.out_valid  = v;
    r.last_out   = l;
    r.byte_count = c;
    make_res = r;
  endfunction

endpackage

`default_nettype wire

// File: sv/ebs_cfg.sv
`default_nettype none

module ebs_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [ebs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                     cfg_data,
  output      ebs_pkg::cfg_t                  cfg_o
);
  import ebs_pkg::*;

  cfg_t cfg_r;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // code registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= START_RESET;
      cfg_r.stop_code   <= STOP_RESET;
      cfg_r.escape_code <= ESCAPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START:  cfg_r.start_code  <= cfg_data;
        CFG_STOP:   cfg_r.stop_code   <= cfg_data;
        CFG_ESCAPE: cfg_r.escape_code <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/ebs_expand.sv
`default_nettype none

module ebs_expand (
  input  wire ebs_pkg::cfg_t                 cfg_i,
  input  wire ebs_pkg::in_t                  item_i,
  input  wire logic                          pend_i,
  input  wire logic [ebs_pkg::COUNT_W-1:0]   count_i,
  output      ebs_pkg::burst_t               burst_o,
  output      logic                          pend_nxt,
  output      logic [ebs_pkg::COUNT_W-1:0]   count_nxt
);
  import ebs_pkg::*;

  logic               hit_frame;
  logic               hit_esc;
  logic [COUNT_W-1:0] c;
  logic [NUM_W-1:0]   n;
  logic               pend;
  burst_t             res;

  assign hit_frame = (item_i.data_byte == cfg_i.start_code) ||
                     (item_i.data_byte == cfg_i.stop_code);
  assign hit_esc   = (item_i.data_byte == cfg_i.escape_code);

  // lay out every result of the beat and the state it leaves
  always_comb begin
    c   = item_i.first_in ? '0 : count_i;
    pend = item_i.first_in ? 1'b0 : pend_i;
    n   = '0;
    res = '0;
    if (item_i.kind) begin
      // encode: optional start, byte or escape pair, optional stop
      if (item_i.first_in) begin
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] = make_res(cfg_i.start_code, 1'b1, 1'b0, c);
        n = n + NUM_W'(1);
      end
      if (hit_frame || hit_esc) begin
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] = make_res(cfg_i.escape_code, 1'b1, 1'b0, c);
        n = n + NUM_W'(1);
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] = make_res(item_i.data_byte + STUFF_OFFSET, 1'b1, 1'b0, c);
        n = n + NUM_W'(1);
      end else begin
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] = make_res(item_i.data_byte, 1'b1, 1'b0, c);
        n = n + NUM_W'(1);
      end
      if (item_i.last_in) begin
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] = make_res(cfg_i.stop_code, 1'b1, 1'b1, c);
        n = n + NUM_W'(1);
        pend = 1'b0;
      end
    end else begin
      // decode: framing codes win over the escape code
      priority if (pend) begin
        pend = 1'b0;
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] =
          make_res(item_i.data_byte - STUFF_OFFSET, 1'b1, item_i.last_in, c);
        n = n + NUM_W'(1);
      end else if (hit_frame) begin
      end else if (hit_esc) begin
        pend = 1'b1;
      end else begin
        c = sat_inc(c);
        res.slot[n[SLOT_W-1:0]] = make_res(item_i.data_byte, 1'b1, item_i.last_in, c);
        n = n + NUM_W'(1);
      end
      // frame end with nothing written gets a bare marker
      if (item_i.last_in) begin
        pend = 1'b0;
        if (n == '0) begin
          res.slot[n[SLOT_W-1:0]] = make_res(8'h00, 1'b0, 1'b1, c);
          n = n + NUM_W'(1);
        end
      end
    end
    res.num = n;
  end

  assign burst_o   = res;
  assign pend_nxt  = pend;
  assign count_nxt = c;

endmodule

`default_nettype wire

// File: sv/ebs_burst.sv
`default_nettype none

module ebs_burst (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire ebs_pkg::burst_t  burst_i,
  output      logic             room,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      ebs_pkg::out_t    out_data
);
  import ebs_pkg::*;

  out_t [MAX_RESULTS-1:0] slots_r;
  logic [NUM_W-1:0]       rem_r;
  logic [SLOT_W-1:0]      rd_r;
  logic                   take;

  assign out_valid = (rem_r != '0);
  assign out_data  = slots_r[rd_r];
  assign take      = out_valid && out_ready;
  // a new beat may land as the last waiting result leaves
  assign room      = (rem_r == '0) || ((rem_r == NUM_W'(1)) && out_ready);

  // result slots, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= burst_i.slot;
    end
  end

  // drain pointer and count of results still waiting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      rem_r <= burst_i.num;
      rd_r  <= '0;
    end else if (take) begin
      rem_r <= rem_r - NUM_W'(1);
      rd_r  <= rd_r + SLOT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: sv/escape_byte_stuffing_codec.sv
// channel  ports                         beat carries
// -------  ----------------------------  -------------------------------------------
// in       in_valid  in_ready  in_data    kind, data_byte, first_in, last_in
// out      out_valid out_ready out_data   out_byte, out_valid, last_out, byte_count
// cfg      cfg_valid cfg_ready cfg_index  cfg_data: start, stop and escape codes
//
// an input beat is expanded in the cycle it is taken and its 0 to 4 results are
// written into a burst register, which drains one result per cycle
// decode beats give at most one result, so decode streams run at one beat per cycle
// an encode beat gives 1 to 4 results and stalls the input until its last one leaves
// synchronous reset restores the default codes and clears count and escape state
// out_ready low stalls the burst register and, once its last result waits, the input
`default_nettype none

module escape_byte_stuffing_codec (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire ebs_pkg::in_t                   in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      ebs_pkg::out_t                  out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [ebs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import ebs_pkg::*;

  cfg_t               cfg;
  burst_t             burst;
  logic               pend_r;
  logic               pend_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               accept;

  assign accept = in_valid && in_ready;

  ebs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ebs_expand u_expand (
    .cfg_i     (cfg),
    .item_i    (in_data),
    .pend_i    (pend_r),
    .count_i   (count_r),
    .burst_o   (burst),
    .pend_nxt  (pend_nxt),
    .count_nxt (count_nxt)
  );

  ebs_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst_i   (burst),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // frame state advances once per taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      count_r <= '0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  // every encode beat leaves at least one result
  a_encode_yields : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind) |=> out_valid)
    else $error("encode beat produced no result");

  // a result without a byte is only ever a frame end marker
  a_bare_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_valid) |-> out_data.last_out)
    else $error("bare result not marked last");

  // a written byte is always counted
  a_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_valid) |-> (out_data.byte_count != '0))
    else $error("byte result with zero count");

  // escape state never survives a frame end
  a_end_clears_escape : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_in) |=> !pend_r)
    else $error("escape pending after frame end");
`endif

endmodule

`default_nettype wire

// File: bench/ebs_tb_pkg.sv
package ebs_tb_pkg;
  import ebs_pkg::*;

  // mode bit of an input beat
  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  localparam int unsigned REPORT_LIMIT = 10;

  class frame_scoreboard;
    logic [7:0]         start_code;
    logic [7:0]         stop_code;
    logic [7:0]         escape_code;
    bit                 escape_pending;
    logic [COUNT_W-1:0] frame_count;
    out_t               expected_q[$];
    int                 beat_results;
    int                 errors;

    function new();
      start_code     = START_RESET;
      stop_code      = STOP_RESET;
      escape_code    = ESCAPE_RESET;
      escape_pending = 1'b0;
      frame_count    = '0;
      beat_results   = 0;
      errors         = 0;
    endfunction

    function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_START:  start_code  = val;
        CFG_STOP:   stop_code   = val;
        CFG_ESCAPE: escape_code = val;
        default: begin
        end
      endcase
    endfunction

    // queue one result, counting written bytes with saturation
    function void add_result(logic [7:0] b, bit v, bit l);
      out_t r;
      if (v && frame_count != COUNT_MAX) frame_count = frame_count + 1'b1;
      r.out_byte   = v ? b : 8'h00;
      r.out_valid  = v;
      r.last_out   = l;
      r.byte_count = frame_count;
      expected_q.push_back(r);
      beat_results++;
    endfunction

    // work out every result of one accepted input beat
    function void note_beat(in_t beat);
      logic [7:0] b;
      b = beat.data_byte;
      beat_results = 0;
      if (beat.first_in) begin
        frame_count    = '0;
        escape_pending = 1'b0;
      end
      if (beat.kind == KIND_ENCODE) begin
        if (beat.first_in) add_result(start_code, 1'b1, 1'b0);
        // any code value gets stuffed
        if (b == start_code || b == stop_code || b == escape_code) begin
          add_result(escape_code, 1'b1, 1'b0);
          add_result(b + STUFF_OFFSET, 1'b1, 1'b0);
        end else begin
          add_result(b, 1'b1, 1'b0);
        end
        if (beat.last_in) begin
          add_result(stop_code, 1'b1, 1'b1);
          escape_pending = 1'b0;
        end
      end else begin
        // framing codes take priority over the escape code
        if (escape_pending) begin
          escape_pending = 1'b0;
          add_result(b - STUFF_OFFSET, 1'b1, beat.last_in);
        end else if (b == start_code || b == stop_code) begin
          // framing code dropped
        end else if (b == escape_code) begin
          escape_pending = 1'b1;
        end else begin
          add_result(b, 1'b1, beat.last_in);
        end
        if (beat.last_in) begin
          escape_pending = 1'b0;
          if (beat_results == 0) add_result(8'h00, 1'b0, 1'b1);
        end
      end
    endfunction

    function void report(string what, out_t e, out_t g);
      if (errors < REPORT_LIMIT)
        $display("%s: exp byte %h valid %b last %b count %0d, got byte %h valid %b last %b count %0d",
                 what, e.out_byte, e.out_valid, e.last_out, e.byte_count,
                 g.out_byte, g.out_valid, g.last_out, g.byte_count);
      errors++;
    endfunction

    // compare one output beat against the oldest expected result
    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        e = expected_q.pop_front();
        if (got.out_byte !== e.out_byte || got.out_valid !== e.out_valid ||
            got.last_out !== e.last_out || got.byte_count !== e.byte_count)
          report("mismatch", e, got);
      end
    endfunction

    // anything still queued at the end never arrived
    function void flush_missing();
      while (expected_q.size() != 0) report("missing result", expected_q.pop_front(), '0);
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ebs_pkg::*;
  import ebs_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 8;
  localparam int SAT_ITEMS     = 345;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  frame_scoreboard codec_sb;
  bit              quiet;
  int              hold_requests;
  int              holds_served;
  int              cycle_cnt;

  escape_byte_stuffing_codec uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: config, input and output beats in a fixed order, plus the cycle limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n === 1'b1) begin
      if (cfg_valid && cfg_ready) codec_sb.set_code(cfg_index, cfg_data);
      if (in_valid && in_ready) codec_sb.note_beat(in_data);
      if (out_valid && out_ready) codec_sb.check_result(out_data);
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver: random back-pressure bursts, one long hold on request
  initial begin : receiver
    holds_served = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_served < hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // offer one beat, with an optional idle burst first, and wait for it to be taken
  task automatic send_beat(input in_t beat);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic k, input logic [7:0] b, input logic f, input logic l);
    in_t beat;
    beat.kind      = k;
    beat.data_byte = b;
    beat.first_in  = f;
    beat.last_in   = l;
    send_beat(beat);
  endtask

  // stop offering and wait until every expected result is out
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (codec_sb.expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three code registers back to back
  task automatic write_codes(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [7:0]           val [3];
    idx[0] = CFG_START;
    idx[1] = CFG_STOP;
    idx[2] = CFG_ESCAPE;
    val[0] = s;
    val[1] = p;
    val[2] = e;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // bytes biased towards the current codes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    pick_byte = codec_sb.escape_code;
      2:       pick_byte = codec_sb.start_code;
      3:       pick_byte = codec_sb.stop_code;
      4:       pick_byte = codec_sb.escape_code + STUFF_OFFSET;
      default: pick_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-framed streams, some mixed modes and broken framing
  task automatic run_random(input int n_items);
    in_t  beat;
    int   sent;
    int   len;
    logic enc;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      enc = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        beat.kind      = ($urandom_range(0, 9) == 0) ? ~enc : enc;
        beat.data_byte = pick_byte();
        beat.first_in  = (k == 0);
        beat.last_in   = (k == len - 1);
        if ($urandom_range(0, 11) == 0) begin
          beat.first_in = 1'($urandom_range(0, 1));
          beat.last_in  = 1'($urandom_range(0, 1));
        end
        send_beat(beat);
        sent++;
      end
    end
  endtask

  // encode code bytes, each beat closing a frame but only the first opening one,
  // so the count runs on at three bytes a beat until it saturates
  task automatic run_saturation(input int n_items);
    in_t beat;
    for (int k = 0; k < n_items; k++) begin
      beat.kind = KIND_ENCODE;
      case ($urandom_range(0, 2))
        0:       beat.data_byte = codec_sb.start_code;
        1:       beat.data_byte = codec_sb.stop_code;
        default: beat.data_byte = codec_sb.escape_code;
      endcase
      beat.first_in = (k == 0);
      beat.last_in  = 1'b1;
      send_beat(beat);
    end
  endtask

  initial begin : stimulus
    codec_sb      = new();
    quiet         = 1'b0;
    hold_requests = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_START;
    cfg_data  <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode frame with extremes and every code, reset codes
    send_fields(KIND_ENCODE, 8'h00, 1'b1, 1'b0);
    send_fields(KIND_ENCODE, 8'hFF, 1'b0, 1'b0);
    send_fields(KIND_ENCODE, START_RESET, 1'b0, 1'b0);
    send_fields(KIND_ENCODE, STOP_RESET, 1'b0, 1'b0);
    send_fields(KIND_ENCODE, ESCAPE_RESET, 1'b0, 1'b1);
    // single-beat frame giving four results
    send_fields(KIND_ENCODE, STOP_RESET, 1'b1, 1'b1);
    // encode beat without first_in
    send_fields(KIND_ENCODE, 8'h55, 1'b0, 1'b1);
    // decode: framing dropped, escaped bytes, escape of escape, bare end marker
    send_fields(KIND_DECODE, START_RESET, 1'b1, 1'b0);
    send_fields(KIND_DECODE, 8'h41, 1'b0, 1'b0);
    send_fields(KIND_DECODE, ESCAPE_RESET, 1'b0, 1'b0);
    send_fields(KIND_DECODE, 8'h21, 1'b0, 1'b0);
    send_fields(KIND_DECODE, ESCAPE_RESET, 1'b0, 1'b0);
    send_fields(KIND_DECODE, ESCAPE_RESET, 1'b0, 1'b0);
    send_fields(KIND_DECODE, ESCAPE_RESET, 1'b0, 1'b0);
    send_fields(KIND_DECODE, 8'h00, 1'b0, 1'b0);
    send_fields(KIND_DECODE, STOP_RESET, 1'b0, 1'b1);
    // dangling escape at frame end
    send_fields(KIND_DECODE, 8'h55, 1'b1, 1'b0);
    send_fields(KIND_DECODE, ESCAPE_RESET, 1'b0, 1'b1);
    // decode single byte frame
    send_fields(KIND_DECODE, 8'hFF, 1'b1, 1'b1);
    // mixed modes: encode beat leaves the pending escape alone
    send_fields(KIND_DECODE, ESCAPE_RESET, 1'b1, 1'b0);
    send_fields(KIND_ENCODE, ESCAPE_RESET, 1'b0, 1'b0);
    send_fields(KIND_DECODE, 8'h41, 1'b0, 1'b1);
    finish_phase();

    // all three codes the same
    write_codes(8'h7E, 8'h7E, 8'h7E);
    send_fields(KIND_DECODE, 8'h7E, 1'b1, 1'b0);
    send_fields(KIND_DECODE, 8'h9E, 1'b0, 1'b1);
    send_fields(KIND_ENCODE, 8'h7E, 1'b1, 1'b1);
    finish_phase();

    // extreme codes, with the long output hold
    write_codes(8'h00, 8'hFF, 8'h80);
    hold_requests++;
    run_random(PHASE_ITEMS);
    finish_phase();

    // escape equal to stop, then saturation
    write_codes(8'hFF, 8'h00, 8'h00);
    run_random(PHASE_ITEMS);
    run_saturation(SAT_ITEMS);
    finish_phase();

    write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    run_random(PHASE_ITEMS);
    finish_phase();

    // start equal to stop
    write_codes(8'h20, 8'h20, 8'h5D);
    run_random(PHASE_ITEMS);
    finish_phase();

    write_codes(8'h7E, 8'h7D, 8'h7E);
    run_random(PHASE_ITEMS);
    finish_phase();

    // last part without idling, back on default codes
    write_codes(START_RESET, STOP_RESET, ESCAPE_RESET);
    quiet = 1'b1;
    run_random(PHASE_ITEMS);
    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);

    codec_sb.flush_missing();
    if (codec_sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
